>>> hdl/rlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_pkg
// Shared widths, codes and types of the line-fit scorer.
// ----------------------------------------------------------------------------
package rlf_pkg;

    localparam int POINT_CAPACITY = 1024;
    localparam int IDX_W   = $clog2(POINT_CAPACITY);
    localparam int CNT_W   = IDX_W + 1;
    localparam int COORD_W = 12;
    localparam int THR_W   = 12;
    localparam int NP_W    = 11;
    localparam int CFG_W   = 12;
    localparam int COEF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * COEF_W;
    localparam int CONST_W = PROD_W + 1;
    localparam int OUT_C_W = 26;
    localparam int NORM_W  = 2 * COEF_W;
    localparam int RHS_W   = 2 * THR_W + NORM_W;
    localparam int DIST_W  = PROD_W + 2;
    localparam int MAG_W   = DIST_W - 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int CMP_W   = SQ_W + 8;
    localparam int MASK_DEPTH = 2 * POINT_CAPACITY;

    // request opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_HYP   = 2'd1;
    localparam logic [1:0] OP_MASK  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EQUAL = 2'd2;

    // register indexes
    localparam logic CFG_NUM_POINTS = 1'b0;
    localparam logic CFG_THRESHOLD  = 1'b1;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_point;

    typedef struct packed {
        logic signed [COEF_W-1:0]  a;
        logic signed [COEF_W-1:0]  b;
        logic signed [CONST_W-1:0] c;
        logic [RHS_W-1:0]          rhs;
    } t_line;

    typedef struct packed {
        logic             valid;
        logic             live;
        logic [IDX_W-1:0] idx;
    } t_tag;

endpackage

>>> hdl/rlf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module rlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/rlf_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlf_score
// Five-stage inlier test of one stored point per cycle against a line.
// ----------------------------------------------------------------------------
module rlf_score (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rlf_pkg::t_line  i_line,
    input  rlf_pkg::t_tag   i_tag,
    input  rlf_pkg::t_point i_pt,
    output rlf_pkg::t_tag   o_tag,
    output logic           o_hit
);

    logic signed [rlf_pkg::PROD_W-1:0] r_au, r_bv;
    logic signed [rlf_pkg::DIST_W-1:0] r_l;
    logic [rlf_pkg::MAG_W-1:0]         r_mag;
    logic [rlf_pkg::SQ_W-1:0]          r_sq;
    logic                              r_hit;
    rlf_pkg::t_tag                     r_tag1, r_tag2, r_tag3, r_tag4, r_tag5;
    logic signed [rlf_pkg::DIST_W-1:0] n_l;
    logic [rlf_pkg::MAG_W-1:0]         n_mag;
    logic [rlf_pkg::CMP_W-1:0]         w_lhs, w_rhs;

    // distance sum and magnitude
    always_comb begin
        n_l = rlf_pkg::DIST_W'(r_au) + rlf_pkg::DIST_W'(r_bv)
            + rlf_pkg::DIST_W'(i_line.c);
        n_mag = r_l[rlf_pkg::DIST_W-1] ? rlf_pkg::MAG_W'(-r_l) : rlf_pkg::MAG_W'(r_l);
        w_lhs = {r_sq, 8'd0};
        w_rhs = rlf_pkg::CMP_W'(i_line.rhs);
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        r_au  <= i_line.a * $signed({1'b0, i_pt.col});
        r_bv  <= i_line.b * $signed({1'b0, i_pt.row});
        r_l   <= n_l;
        r_mag <= n_mag;
        r_sq  <= r_mag * r_mag;
        r_hit <= r_tag4.live && (w_lhs < w_rhs);
    end

    // tag pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_tag4 <= '0;
            r_tag5 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
            r_tag3 <= r_tag2;
            r_tag4 <= r_tag3;
            r_tag5 <= r_tag4;
        end
    end

    assign o_tag = r_tag5;
    assign o_hit = r_hit;

endmodule

>>> hdl/ransac_line_fit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ransac_line_fit_top
// Line hypothesis scorer over a stored point set with a two-bank best mask.
// ----------------------------------------------------------------------------
// Usage: requests enter on i_valid/o_ready with an opcode and operands; each
// request gives exactly one result on o_valid/i_ready. o_ready is high only
// while the sequencer is idle, so one request is in flight at a time, but a
// new request is taken while the previous result still waits in the output
// register. Load, clear and rejected requests go through S_FIN to the result,
// a mask read through S_MREAD and S_FIN. A hypothesis reads its two points,
// forms the line and the squared threshold bound in S_CA to S_CR, then
// sweeps the point memory one entry per cycle through a five-stage scoring
// pipe, covering every entry through the single read port of
// the point memory. If the receiver stalls, the sequencer holds the next
// result until the output register frees up. Reset clears the best line,
// count and bank select and sets num_points to 2 and the threshold to 16;
// the point memory is undefined until loaded; the mask banks need no clearing
// pass, as the best bank reads as zero while the best count is zero. The user
// writes configuration on i_cfg_we while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ransac_line_fit_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_index,
    input  logic [rlf_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_op,
    input  logic [rlf_pkg::IDX_W-1:0]           i_first_index,
    input  logic [rlf_pkg::IDX_W-1:0]           i_second_index,
    input  logic [rlf_pkg::COORD_W-1:0]         i_row,
    input  logic [rlf_pkg::COORD_W-1:0]         i_col,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic                                o_improved,
    output logic [rlf_pkg::CNT_W-1:0]           o_hypothesis_inliers,
    output logic [rlf_pkg::CNT_W-1:0]           o_best_inliers,
    output logic signed [rlf_pkg::COEF_W-1:0]   o_best_a,
    output logic signed [rlf_pkg::COEF_W-1:0]   o_best_b,
    output logic signed [rlf_pkg::OUT_C_W-1:0]  o_best_c,
    output logic                                o_mask_bit
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD1   = 4'd1;
    localparam logic [3:0] S_RD2   = 4'd2;
    localparam logic [3:0] S_CA    = 4'd3;
    localparam logic [3:0] S_CU    = 4'd4;
    localparam logic [3:0] S_CC    = 4'd5;
    localparam logic [3:0] S_CS    = 4'd6;
    localparam logic [3:0] S_CR    = 4'd7;
    localparam logic [3:0] S_SWEEP = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_MREAD = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0]                        r_state;
    logic [rlf_pkg::NP_W-1:0]          r_num_points;
    logic [rlf_pkg::THR_W-1:0]         r_thr;
    logic                              r_sel;
    logic [rlf_pkg::CNT_W-1:0]         r_best_cnt;
    logic signed [rlf_pkg::COEF_W-1:0] r_best_a, r_best_b;
    logic signed [rlf_pkg::CONST_W-1:0] r_best_c;
    logic [rlf_pkg::IDX_W-1:0]         r_i1;
    rlf_pkg::t_point                   r_p0, r_p1;
    logic signed [rlf_pkg::PROD_W-1:0] r_pu, r_pv, r_a2, r_b2;
    logic [rlf_pkg::NORM_W-1:0]        r_s;
    logic [2*rlf_pkg::THR_W-1:0]       r_t;
    rlf_pkg::t_line                    r_line;
    logic [rlf_pkg::CNT_W-1:0]         r_j;
    logic [rlf_pkg::CNT_W-1:0]         r_cnt;
    rlf_pkg::t_tag                     r_rd_tag;
    logic [1:0]                        r_status;
    logic                              r_improved;
    logic [rlf_pkg::CNT_W-1:0]         r_hyp;
    logic                              r_mbit;
    logic                              r_out_valid;
    logic [1:0]                        r_o_status;
    logic                              r_o_improved;
    logic [rlf_pkg::CNT_W-1:0]         r_o_hyp, r_o_best;
    logic signed [rlf_pkg::COEF_W-1:0] r_o_a, r_o_b;
    logic signed [rlf_pkg::OUT_C_W-1:0] r_o_c;
    logic                              r_o_mbit;

    logic                              w_acc;
    logic [rlf_pkg::CNT_W-1:0]         w_n;
    logic                              w_rng0, w_rng1;
    logic [1:0]                        w_req_status;
    logic [3:0]                        w_req_state;
    logic                              w_pt_we;
    logic [rlf_pkg::IDX_W-1:0]         w_pt_addr;
    rlf_pkg::t_point                   w_pt_wdata, w_pt_rdata;
    logic [rlf_pkg::IDX_W:0]           w_mk_raddr, w_mk_waddr;
    logic                              w_mk_rdata;
    rlf_pkg::t_tag                     w_hit_tag;
    logic                              w_hit;
    logic                              w_out_load;

    // active count and request checks
    always_comb begin
        w_n = (r_num_points > rlf_pkg::NP_W'(rlf_pkg::POINT_CAPACITY))
            ? rlf_pkg::CNT_W'(rlf_pkg::POINT_CAPACITY) : rlf_pkg::CNT_W'(r_num_points);
        w_acc  = i_valid && o_ready;
        w_rng0 = {1'b0, i_first_index} >= w_n;
        w_rng1 = {1'b0, i_second_index} >= w_n;
        w_out_load = (r_state == S_FIN) && (!r_out_valid || i_ready);
    end

    // status and next state of a new request
    always_comb begin
        w_req_status = rlf_pkg::ST_OK;
        w_req_state  = S_FIN;
        case (i_op)
            rlf_pkg::OP_LOAD: begin
                if (w_rng0) w_req_status = rlf_pkg::ST_RANGE;
            end
            rlf_pkg::OP_HYP: begin
                if (w_rng0 || w_rng1) begin
                    w_req_status = rlf_pkg::ST_RANGE;
                end else if (i_first_index == i_second_index) begin
                    w_req_status = rlf_pkg::ST_EQUAL;
                end else begin
                    w_req_state = S_RD1;
                end
            end
            rlf_pkg::OP_MASK: begin
                if (w_rng0) w_req_status = rlf_pkg::ST_RANGE;
                else w_req_state = S_MREAD;
            end
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    // point memory port selection
    always_comb begin
        w_pt_we = w_acc && (i_op == rlf_pkg::OP_LOAD) && !w_rng0;
        w_pt_wdata.row = i_row;
        w_pt_wdata.col = i_col;
        case (r_state)
            S_RD1:   w_pt_addr = r_i1;
            S_SWEEP: w_pt_addr = r_j[rlf_pkg::IDX_W-1:0];
            default: w_pt_addr = i_first_index;
        endcase
        w_mk_raddr = {r_sel, i_first_index};
        w_mk_waddr = {~r_sel, w_hit_tag.idx};
    end

    rlf_ram #(
        .WIDTH (2 * rlf_pkg::COORD_W),
        .DEPTH (rlf_pkg::POINT_CAPACITY)
    ) u_point_ram (
        .i_clk   (i_clk),
        .i_we    (w_pt_we),
        .i_waddr (i_first_index),
        .i_wdata (w_pt_wdata),
        .i_raddr (w_pt_addr),
        .o_rdata (w_pt_rdata)
    );

    rlf_ram #(
        .WIDTH (1),
        .DEPTH (rlf_pkg::MASK_DEPTH)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (w_hit_tag.valid),
        .i_waddr (w_mk_waddr),
        .i_wdata (w_hit),
        .i_raddr (w_mk_raddr),
        .o_rdata (w_mk_rdata)
    );

    rlf_score u_score (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_line  (r_line),
        .i_tag   (r_rd_tag),
        .i_pt    (w_pt_rdata),
        .o_tag   (w_hit_tag),
        .o_hit   (w_hit)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points <= rlf_pkg::NP_W'(2);
            r_thr        <= rlf_pkg::THR_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rlf_pkg::CFG_NUM_POINTS: r_num_points <= i_cfg_data[rlf_pkg::NP_W-1:0];
                rlf_pkg::CFG_THRESHOLD:  r_thr <= i_cfg_data[rlf_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // line setup datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_RD1: r_p0 <= w_pt_rdata;
            S_RD2: r_p1 <= w_pt_rdata;
            S_CA: begin
                if (r_p0.row != r_p1.row) begin
                    r_line.a <= $signed({1'b0, r_p0.row}) - $signed({1'b0, r_p1.row});
                    r_line.b <= $signed({1'b0, r_p1.col}) - $signed({1'b0, r_p0.col});
                end else begin
                    r_line.a <= '0;
                    r_line.b <= rlf_pkg::COEF_W'(1);
                end
            end
            S_CU: begin
                r_pu <= r_line.a * $signed({1'b0, r_p0.col});
                r_pv <= r_line.b * $signed({1'b0, r_p0.row});
            end
            S_CC: begin
                r_line.c <= -rlf_pkg::CONST_W'(r_pu) - rlf_pkg::CONST_W'(r_pv);
                r_a2 <= r_line.a * r_line.a;
                r_b2 <= r_line.b * r_line.b;
                r_t  <= r_thr * r_thr;
            end
            S_CS: r_s <= rlf_pkg::NORM_W'(r_a2) + rlf_pkg::NORM_W'(r_b2);
            S_CR: r_line.rhs <= rlf_pkg::RHS_W'(r_t) * rlf_pkg::RHS_W'(r_s);
            default: ;
        endcase
    end

    // sequencer and best-line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sel      <= 1'b0;
            r_best_cnt <= '0;
            r_best_a   <= '0;
            r_best_b   <= '0;
            r_best_c   <= '0;
            r_rd_tag   <= '0;
        end else begin
            r_rd_tag.valid <= (r_state == S_SWEEP) && !r_j[rlf_pkg::IDX_W];
            r_rd_tag.live  <= r_j < w_n;
            r_rd_tag.idx   <= r_j[rlf_pkg::IDX_W-1:0];
            if (w_hit_tag.valid) begin
                r_cnt <= r_cnt + rlf_pkg::CNT_W'(w_hit);
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_improved <= 1'b0;
                        r_hyp      <= '0;
                        r_mbit     <= 1'b0;
                        r_status   <= w_req_status;
                        r_i1       <= i_second_index;
                        r_state    <= w_req_state;
                        if (i_op == rlf_pkg::OP_CLEAR) begin
                            r_sel      <= 1'b0;
                            r_best_cnt <= '0;
                            r_best_a   <= '0;
                            r_best_b   <= '0;
                            r_best_c   <= '0;
                        end
                    end
                end
                S_RD1: r_state <= S_RD2;
                S_RD2: r_state <= S_CA;
                S_CA:  r_state <= S_CU;
                S_CU:  r_state <= S_CC;
                S_CC:  r_state <= S_CS;
                S_CS:  r_state <= S_CR;
                S_CR: begin
                    r_j     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (!r_j[rlf_pkg::IDX_W]) r_j <= r_j + 1'b1;
                    if (w_hit_tag.valid && (&w_hit_tag.idx)) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_hyp <= r_cnt;
                    if (r_cnt > r_best_cnt) begin
                        r_best_cnt <= r_cnt;
                        r_best_a   <= r_line.a;
                        r_best_b   <= r_line.b;
                        r_best_c   <= r_line.c;
                        r_sel      <= ~r_sel;
                        r_improved <= 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_MREAD: begin
                    r_mbit  <= w_mk_rdata && (r_best_cnt != '0);
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_out_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_out_load) begin
            r_o_status   <= r_status;
            r_o_improved <= r_improved;
            r_o_hyp      <= r_hyp;
            r_o_best     <= r_best_cnt;
            r_o_a        <= r_best_a;
            r_o_b        <= r_best_b;
            r_o_c        <= r_best_c[rlf_pkg::OUT_C_W-1:0];
            r_o_mbit     <= r_mbit;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_status             = r_o_status;
    assign o_improved           = r_o_improved;
    assign o_hypothesis_inliers = r_o_hyp;
    assign o_best_inliers       = r_o_best;
    assign o_best_a             = r_o_a;
    assign o_best_b             = r_o_b;
    assign o_best_c             = r_o_c;
    assign o_mask_bit           = r_o_mbit;

    // point memory is written only by an accepted load
    a_pt_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pt_we |-> (r_state == S_IDLE))
        else $error("point write outside idle");

    // mask writes come only from a running sweep
    a_mask_write_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit_tag.valid |-> (r_state == S_SWEEP))
        else $error("mask write outside sweep");

    // an improving hypothesis becomes the best count
    a_best_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_cnt > r_best_cnt) |=> (r_best_cnt == $past(r_cnt)))
        else $error("best count not updated");

    // hypothesis count never exceeds the active point count
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_cnt <= w_n))
        else $error("inlier count above point count");

endmodule
